// ===== rtl/vtbi_pkg.sv =====
package vtbi_pkg;

	// Request kinds
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_TICK  = 1'b1;

	// Register numbers
	localparam logic [3:0] REG_ORB    = 4'h0;
	localparam logic [3:0] REG_ORA    = 4'h1;
	localparam logic [3:0] REG_DDRB   = 4'h2;
	localparam logic [3:0] REG_DDRA   = 4'h3;
	localparam logic [3:0] REG_T1CL   = 4'h4;
	localparam logic [3:0] REG_T1CH   = 4'h5;
	localparam logic [3:0] REG_T1LL   = 4'h6;
	localparam logic [3:0] REG_T1LH   = 4'h7;
	localparam logic [3:0] REG_T2CL   = 4'h8;
	localparam logic [3:0] REG_T2CH   = 4'h9;
	localparam logic [3:0] REG_SR     = 4'ha;
	localparam logic [3:0] REG_ACR    = 4'hb;
	localparam logic [3:0] REG_PCR    = 4'hc;
	localparam logic [3:0] REG_IFR    = 4'hd;
	localparam logic [3:0] REG_IER    = 4'he;
	localparam logic [3:0] REG_ORA_NH = 4'hf;

	// Handshake line modes in a PCR nibble (bits 3:1 or 7:5)
	localparam logic [2:0] HS_PULSE_WR = 3'b100;
	localparam logic [2:0] HS_PULSE    = 3'b101;
	localparam logic [2:0] HS_LOW      = 3'b110;

	// Demultiplexer selects on port B bits 2:1
	localparam logic [1:0] MUX_Y   = 2'b00;
	localparam logic [1:0] MUX_REF = 2'b01;

	// Interrupt flag bits
	localparam int IFR_T1  = 6;
	localparam int IFR_T2  = 5;
	localparam int IFR_SR  = 2;

	localparam int         BEAM_CENTRE = 16383;
	localparam logic [7:0] SH_RESET    = 8'h80;
	localparam int         OUT_BITS    = 24;

	typedef struct packed {
		logic       req_type;
		logic [3:0] reg_addr;
		logic [7:0] wr_data;
	} req_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] beam_x;
		logic signed [OUT_BITS-1:0] beam_y;
		logic                       irq_out;
		logic                       ca2_level;
		logic                       cb2_level;
		logic                       pb7_level;
	} rsp_t;

endpackage

// ===== rtl/via_timer_and_beam_integrator_top.sv =====
// Interface chip timer with vector beam integrator.
// Request channel (req_valid, req_stall, req): a request is either a register
// write (reg_addr, wr_data) or one clock tick. Response channel (rsp_valid,
// rsp_stall, rsp): exactly one response per request, in order, carrying the
// beam position, the IRQ summary and the CA2, CB2 and PB7 levels after the
// request has taken effect.
// The request is captured in an input register, then the whole update of the
// timer, flags and beam runs in one pass into the response register. One
// request is taken every cycle while the response side keeps up.
// When rsp_stall holds a response, the input register still takes one more
// request, then req_stall rises until the response is taken.
// Reset (arst_n low) clears both stages, puts the beam at the centre, the
// sample-and-holds at mid scale and all chip registers at zero.
// Beam positions are BEAM_BITS wide and saturate; the response carries
// their low 24 bits.
module via_timer_and_beam_integrator_top #(
	parameter int BEAM_BITS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  vtbi_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output vtbi_pkg::rsp_t rsp
);

	localparam logic signed [BEAM_BITS-1:0] PosCentre = BEAM_BITS'(vtbi_pkg::BEAM_CENTRE);
	localparam logic signed [BEAM_BITS-1:0] PosMax    = {1'b0, {(BEAM_BITS-1){1'b1}}};
	localparam logic signed [BEAM_BITS-1:0] PosMin    = {1'b1, {(BEAM_BITS-1){1'b0}}};

	// Pipeline control
	logic           valid_s1;
	vtbi_pkg::req_t req_s1;
	logic           advance;

	// Chip state
	logic [7:0]  port_b_q;
	logic [15:0] t1_count_q;
	logic [7:0]  t1_latch_lo_q, t1_latch_hi_q;
	logic        t1_running_q, t1_armed_q, t1_pb7_q;
	logic [1:0]  acr_q;          // ACR bits 7:6
	logic [6:0]  pcr_q;          // PCR bits 7:1
	logic [7:0]  ifr_q;
	logic [6:0]  ier_q;
	logic        ca2_q, cb2_q;
	logic [7:0]  sh_ref_q, sh_x_q, sh_y_q;
	logic signed [BEAM_BITS-1:0] pos_x_q, pos_y_q;

	// Next state
	logic [7:0]  port_b_d;
	logic [15:0] t1_count_d;
	logic [7:0]  t1_latch_lo_d, t1_latch_hi_d;
	logic        t1_running_d, t1_armed_d, t1_pb7_d;
	logic [1:0]  acr_d;
	logic [6:0]  pcr_d;
	logic [7:0]  ifr_d;
	logic [6:0]  ier_d;
	logic        ca2_d, cb2_d;
	logic [7:0]  sh_ref_d, sh_x_d, sh_y_d;
	logic signed [BEAM_BITS-1:0] pos_x_d, pos_y_d;

	logic signed [8:0]         dx, dy;
	logic signed [BEAM_BITS:0] sum_x, sum_y;
	logic signed [31:0]        ext_x, ext_y;

	assign advance   = !rsp_valid || !rsp_stall;
	assign req_stall = valid_s1 && !advance;

	// Capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
	end

	// Beam deltas follow the sample-and-holds
	assign dx = 9'(signed'({1'b0, sh_x_q})) - 9'(signed'({1'b0, sh_ref_q}));
	assign dy = 9'(signed'({1'b0, sh_ref_q})) - 9'(signed'({1'b0, sh_y_q}));
	assign sum_x = (BEAM_BITS+1)'(pos_x_q) + (BEAM_BITS+1)'(dx);
	assign sum_y = (BEAM_BITS+1)'(pos_y_q) + (BEAM_BITS+1)'(dy);

	// Work out the effect of one request
	always_comb begin
		logic ramp;
		port_b_d      = port_b_q;
		t1_count_d    = t1_count_q;
		t1_latch_lo_d = t1_latch_lo_q;
		t1_latch_hi_d = t1_latch_hi_q;
		t1_running_d  = t1_running_q;
		t1_armed_d    = t1_armed_q;
		t1_pb7_d      = t1_pb7_q;
		acr_d         = acr_q;
		pcr_d         = pcr_q;
		ifr_d         = ifr_q;
		ier_d         = ier_q;
		ca2_d         = ca2_q;
		cb2_d         = cb2_q;
		sh_ref_d      = sh_ref_q;
		sh_x_d        = sh_x_q;
		sh_y_d        = sh_y_q;
		pos_x_d       = pos_x_q;
		pos_y_d       = pos_y_q;
		ramp          = 1'b1;

		if (req_s1.req_type == vtbi_pkg::REQ_WRITE) begin
			unique case (req_s1.reg_addr)
				vtbi_pkg::REG_ORB: begin
					port_b_d = req_s1.wr_data;
					if (pcr_q[6:4] == vtbi_pkg::HS_PULSE_WR) cb2_d = 1'b0;
				end
				vtbi_pkg::REG_ORA, vtbi_pkg::REG_ORA_NH: begin
					sh_x_d = req_s1.wr_data ^ 8'h80;
					if (req_s1.reg_addr == vtbi_pkg::REG_ORA &&
					    pcr_q[2:0] == vtbi_pkg::HS_PULSE_WR) ca2_d = 1'b0;
				end
				vtbi_pkg::REG_T1CL, vtbi_pkg::REG_T1LL: t1_latch_lo_d = req_s1.wr_data;
				vtbi_pkg::REG_T1CH: begin
					t1_latch_hi_d = req_s1.wr_data;
					t1_count_d    = {req_s1.wr_data, t1_latch_lo_q};
					ifr_d[vtbi_pkg::IFR_T1] = 1'b0;
					t1_running_d  = 1'b1;
					t1_armed_d    = 1'b1;
					t1_pb7_d      = 1'b0;
				end
				vtbi_pkg::REG_T1LH: t1_latch_hi_d = req_s1.wr_data;
				vtbi_pkg::REG_T2CH: ifr_d[vtbi_pkg::IFR_T2] = 1'b0;
				vtbi_pkg::REG_SR:   ifr_d[vtbi_pkg::IFR_SR] = 1'b0;
				vtbi_pkg::REG_ACR:  acr_d = req_s1.wr_data[7:6];
				vtbi_pkg::REG_PCR: begin
					pcr_d = req_s1.wr_data[7:1];
					ca2_d = req_s1.wr_data[3:1] != vtbi_pkg::HS_LOW;
					cb2_d = req_s1.wr_data[7:5] != vtbi_pkg::HS_LOW;
				end
				vtbi_pkg::REG_IFR: ifr_d[6:0] = ifr_q[6:0] & ~req_s1.wr_data[6:0];
				vtbi_pkg::REG_IER: begin
					if (req_s1.wr_data[7]) ier_d = ier_q | req_s1.wr_data[6:0];
					else                   ier_d = ier_q & ~req_s1.wr_data[6:0];
				end
				vtbi_pkg::REG_DDRB, vtbi_pkg::REG_DDRA, vtbi_pkg::REG_T2CL: begin
				end
				default: begin
				end
			endcase

			// Route the x sample to the selected hold on port writes
			if ((req_s1.reg_addr == vtbi_pkg::REG_ORB ||
			     req_s1.reg_addr == vtbi_pkg::REG_ORA ||
			     req_s1.reg_addr == vtbi_pkg::REG_ORA_NH) && !port_b_d[0]) begin
				if (port_b_d[2:1] == vtbi_pkg::MUX_Y)   sh_y_d   = sh_x_d;
				if (port_b_d[2:1] == vtbi_pkg::MUX_REF) sh_ref_d = sh_x_d;
			end

			// Refresh the IRQ summary where the chip does
			if (req_s1.reg_addr == vtbi_pkg::REG_T1CH || req_s1.reg_addr == vtbi_pkg::REG_T2CH ||
			    req_s1.reg_addr == vtbi_pkg::REG_SR || req_s1.reg_addr == vtbi_pkg::REG_IFR ||
			    req_s1.reg_addr == vtbi_pkg::REG_IER) begin
				ifr_d[7] = |(ifr_d[6:0] & ier_d);
			end
		end else begin
			// Count timer 1 down and handle rollover
			if (t1_running_q) begin
				t1_count_d = t1_count_q - 16'd1;
				if (t1_count_q == 16'd0) begin
					if (acr_q[0]) begin
						ifr_d[vtbi_pkg::IFR_T1] = 1'b1;
						ifr_d[7]   = |(ifr_d[6:0] & ier_q);
						t1_pb7_d   = !t1_pb7_q;
						t1_count_d = {t1_latch_hi_q, t1_latch_lo_q};
					end else if (t1_armed_q) begin
						ifr_d[vtbi_pkg::IFR_T1] = 1'b1;
						ifr_d[7]   = |(ifr_d[6:0] & ier_q);
						t1_pb7_d   = 1'b1;
						t1_armed_d = 1'b0;
					end
				end
			end

			// Move the beam, or hold it at the centre while CA2 is low
			ramp = acr_q[1] ? t1_pb7_d : port_b_q[7];
			if (!ca2_q) begin
				pos_x_d = PosCentre;
				pos_y_d = PosCentre;
			end else if (!ramp) begin
				if (sum_x[BEAM_BITS] != sum_x[BEAM_BITS-1])
					pos_x_d = sum_x[BEAM_BITS] ? PosMin : PosMax;
				else
					pos_x_d = sum_x[BEAM_BITS-1:0];
				if (sum_y[BEAM_BITS] != sum_y[BEAM_BITS-1])
					pos_y_d = sum_y[BEAM_BITS] ? PosMin : PosMax;
				else
					pos_y_d = sum_y[BEAM_BITS-1:0];
			end

			// Restore pulsed handshake lines
			if (pcr_q[2:0] == vtbi_pkg::HS_PULSE) ca2_d = 1'b1;
			if (pcr_q[6:4] == vtbi_pkg::HS_PULSE) cb2_d = 1'b1;
		end
	end

	// Advance the chip state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_b_q      <= '0;
			t1_count_q    <= '0;
			t1_latch_lo_q <= '0;
			t1_latch_hi_q <= '0;
			t1_running_q  <= 1'b0;
			t1_armed_q    <= 1'b0;
			t1_pb7_q      <= 1'b0;
			acr_q         <= '0;
			pcr_q         <= '0;
			ifr_q         <= '0;
			ier_q         <= '0;
			ca2_q         <= 1'b0;
			cb2_q         <= 1'b0;
			sh_ref_q      <= vtbi_pkg::SH_RESET;
			sh_x_q        <= vtbi_pkg::SH_RESET;
			sh_y_q        <= vtbi_pkg::SH_RESET;
			pos_x_q       <= PosCentre;
			pos_y_q       <= PosCentre;
		end else if (valid_s1 && advance) begin
			port_b_q      <= port_b_d;
			t1_count_q    <= t1_count_d;
			t1_latch_lo_q <= t1_latch_lo_d;
			t1_latch_hi_q <= t1_latch_hi_d;
			t1_running_q  <= t1_running_d;
			t1_armed_q    <= t1_armed_d;
			t1_pb7_q      <= t1_pb7_d;
			acr_q         <= acr_d;
			pcr_q         <= pcr_d;
			ifr_q         <= ifr_d;
			ier_q         <= ier_d;
			ca2_q         <= ca2_d;
			cb2_q         <= cb2_d;
			sh_ref_q      <= sh_ref_d;
			sh_x_q        <= sh_x_d;
			sh_y_q        <= sh_y_d;
			pos_x_q       <= pos_x_d;
			pos_y_q       <= pos_y_d;
		end
	end

	// Sign-extend or truncate the positions to the response width
	assign ext_x = 32'(pos_x_d);
	assign ext_y = 32'(pos_y_d);

	// Hold the response until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (advance) begin
			rsp_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp.beam_x    <= ext_x[vtbi_pkg::OUT_BITS-1:0];
			rsp.beam_y    <= ext_y[vtbi_pkg::OUT_BITS-1:0];
			rsp.irq_out   <= ifr_d[7];
			rsp.ca2_level <= ca2_d;
			rsp.cb2_level <= cb2_d;
			rsp.pb7_level <= t1_pb7_d;
		end
	end

endmodule
